// File: hdl/pdgb_pkg.sv
// Package for the particle step pipeline: beat types, stage numbering,
// register indexes and saturation helpers. No dependencies.
package pdgb_pkg;

    localparam int SQ_BITS   = 24;
    localparam int ST_IN     = 0;
    localparam int ST_MUL    = 1;
    localparam int ST_SUM    = 2;
    localparam int ST_SQ0    = 3;
    localparam int ST_F      = ST_SQ0 + SQ_BITS;
    localparam int ST_DMUL   = ST_F + 1;
    localparam int ST_DSUB   = ST_F + 2;
    localparam int ST_GRAV   = ST_F + 3;
    localparam int ST_PMUL   = ST_F + 4;
    localparam int ST_PADD   = ST_F + 5;
    localparam int ST_BOUNCE = ST_F + 6;
    localparam int N_STAGES  = ST_BOUNCE + 1;

    localparam logic [7:0] REG_GRAVITY = 8'd0;
    localparam logic [7:0] REG_DRAG    = 8'd1;
    localparam logic [7:0] REG_WIDTH   = 8'd2;
    localparam logic [7:0] REG_HEIGHT  = 8'd3;

    localparam logic signed [23:0] Q_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] Q_MIN = -24'sh800000;

    typedef struct packed {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic [7:0]         r;
        logic [15:0]        dt;
        logic [31:0]        kd;
        logic signed [23:0] gd;
        logic [46:0]        sqx;
        logic [46:0]        sqy;
        logic [47:0]        rem;
        logic [47:0]        res;
        logic [31:0]        f;
        logic [55:0]        mx;
        logic [55:0]        my;
        logic [39:0]        dpx;
        logic [39:0]        dpy;
    } item_t;

    function automatic logic signed [23:0] sat24(input logic signed [41:0] v);
        if (v > 42'(Q_MAX)) return Q_MAX;
        if (v < 42'(Q_MIN)) return Q_MIN;
        return v[23:0];
    endfunction

    function automatic logic [23:0] mag24(input logic signed [23:0] v);
        return v[23] ? 24'(-v) : v;
    endfunction

    function automatic logic signed [41:0] apply_sign(input logic neg,
                                                      input logic [39:0] m);
        return neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
    endfunction

    function automatic logic signed [23:0] neg_sat(input logic signed [23:0] v);
        return (v == Q_MIN) ? Q_MAX : -v;
    endfunction

endpackage

// File: hdl/particle_drag_gravity_bounce_step.sv
// Pipelined Euler step for one ball: drag, gravity, position, wall bounce.
// Depends on pdgb_pkg.
//
// channel   dir  handshake                 payload
// s_        in   s_tvalid / s_tready       s_tdata: item fields
// m_        out  m_tvalid / m_tready       m_tdata: result fields
// cfg_      in   cfg_valid / cfg_ready     cfg_addr, cfg_data
//
// One beat per cycle in while the output is not stalled.
// The pipeline depth comes mostly from the bit-serial square root, one result bit a stage.
// A stalled output holds the whole pipeline; nothing is dropped.
// aresetn clears valid bits and loads register defaults; cfg_ready stays high.
module particle_drag_gravity_bounce_step (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, vel_x, vel_y, ball_radius, time_step
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_pos_x, new_pos_y, new_vel_x, new_vel_y
    output logic [95:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_addr,
    input  logic [23:0]  cfg_data
);

    localparam int N = pdgb_pkg::N_STAGES;

    pdgb_pkg::item_t    pipe_reg  [N];
    pdgb_pkg::item_t    pipe_next [N];
    logic [N-1:0]       valid_reg;
    logic               adv;

    logic signed [23:0] grav_reg;
    logic [15:0]        drag_reg;
    logic [11:0]        width_reg;
    logic [11:0]        height_reg;

    assign adv       = m_tready || !valid_reg[N-1];
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = valid_reg[N-1];
    assign m_tdata   = {pipe_reg[N-1].vy, pipe_reg[N-1].vx,
                        pipe_reg[N-1].py, pipe_reg[N-1].px};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_reg   <= 24'sd128000;
            drag_reg   <= 16'd655;
            width_reg  <= 12'd800;
            height_reg <= 12'd600;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                pdgb_pkg::REG_GRAVITY: grav_reg   <= cfg_data;
                pdgb_pkg::REG_DRAG:    drag_reg   <= cfg_data[15:0];
                pdgb_pkg::REG_WIDTH:   width_reg  <= cfg_data[11:0];
                pdgb_pkg::REG_HEIGHT:  height_reg <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        pdgb_pkg::item_t    d;
        logic [47:0]        bitv;
        logic [47:0]        trial;
        logic [55:0]        prod;
        logic [39:0]        gprod;
        logic signed [22:0] limx;
        logic signed [22:0] limy;
        logic               hitx;
        logic               hity;
        d        = '0;
        pipe_next[0]    = '0;
        pipe_next[0].px = s_tdata[23:0];
        pipe_next[0].py = s_tdata[47:24];
        pipe_next[0].vx = s_tdata[71:48];
        pipe_next[0].vy = s_tdata[95:72];
        pipe_next[0].r  = s_tdata[103:96];
        pipe_next[0].dt = s_tdata[119:104];
        for (int s = 1; s < N; s++) begin
            d     = pipe_reg[s-1];
            bitv  = '0;
            trial = '0;
            prod  = '0;
            gprod = '0;
            limx  = '0;
            limy  = '0;
            hitx  = 1'b0;
            hity  = 1'b0;
            if (s == pdgb_pkg::ST_MUL) begin
                d.sqx = 47'(pdgb_pkg::mag24(d.vx) * pdgb_pkg::mag24(d.vx));
                d.sqy = 47'(pdgb_pkg::mag24(d.vy) * pdgb_pkg::mag24(d.vy));
                d.kd  = drag_reg * d.dt;
                gprod = pdgb_pkg::mag24(grav_reg) * d.dt;
                d.gd  = grav_reg[23] ? -$signed(gprod[39:16]) : $signed(gprod[39:16]);
            end else if (s == pdgb_pkg::ST_SUM) begin
                d.rem = {1'b0, d.sqx} + {1'b0, d.sqy};
                d.res = '0;
            end else if (s >= pdgb_pkg::ST_SQ0 && s < pdgb_pkg::ST_F) begin
                bitv  = 48'(1) << (2 * (pdgb_pkg::ST_F - 1 - s));
                trial = d.res + bitv;
                if (d.rem >= trial) begin
                    d.rem = d.rem - trial;
                    d.res = (d.res >> 1) + bitv;
                end else begin
                    d.res = d.res >> 1;
                end
            end else if (s == pdgb_pkg::ST_F) begin
                prod = d.kd * d.res[23:0];
                d.f  = prod[55:24];
            end else if (s == pdgb_pkg::ST_DMUL) begin
                d.mx = pdgb_pkg::mag24(d.vx) * d.f;
                d.my = pdgb_pkg::mag24(d.vy) * d.f;
            end else if (s == pdgb_pkg::ST_DSUB) begin
                d.vx = pdgb_pkg::sat24(42'(d.vx)
                       - pdgb_pkg::apply_sign(d.vx[23], d.mx[55:16]));
                d.vy = pdgb_pkg::sat24(42'(d.vy)
                       - pdgb_pkg::apply_sign(d.vy[23], d.my[55:16]));
            end else if (s == pdgb_pkg::ST_GRAV) begin
                d.vy = pdgb_pkg::sat24(42'(d.vy) + 42'(d.gd));
            end else if (s == pdgb_pkg::ST_PMUL) begin
                d.dpx = pdgb_pkg::mag24(d.vx) * d.dt;
                d.dpy = pdgb_pkg::mag24(d.vy) * d.dt;
            end else if (s == pdgb_pkg::ST_PADD) begin
                d.px = pdgb_pkg::sat24(42'(d.px)
                       + pdgb_pkg::apply_sign(d.vx[23], {16'd0, d.dpx[39:16]}));
                d.py = pdgb_pkg::sat24(42'(d.py)
                       + pdgb_pkg::apply_sign(d.vy[23], {16'd0, d.dpy[39:16]}));
            end else begin
                limx = 23'(($signed({2'b00, width_reg})
                       - $signed({5'd0, d.r, 1'b0})) * 256);
                limy = 23'(($signed({2'b00, height_reg})
                       - $signed({5'd0, d.r, 1'b0})) * 256);
                hitx = (d.px <= 0) || (d.px >= 24'(limx));
                hity = (d.py <= 0) || (d.py >= 24'(limy));
                if (hitx) d.vx = pdgb_pkg::neg_sat(d.vx);
                if (hity) d.vy = pdgb_pkg::neg_sat(d.vy);
            end
            pipe_next[s] = d;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[N-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int s = 0; s < N; s++) begin
                pipe_reg[s] <= pipe_next[s];
            end
        end
    end

endmodule

// File: hdl/pdgb_checker.sv
// Port-level checks for the particle step pipeline, bound to the top level.
// Depends on particle_drag_gravity_bounce_step.
module pdgb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("output beat dropped under stall");

    a_data_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("output beat changed under stall");

endmodule

bind particle_drag_gravity_bounce_step pdgb_checker u_pdgb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/sv/particle_drag_gravity_bounce_step_tb.sv
`timescale 1ns / 100ps
// Testbench for particle_drag_gravity_bounce_step: directed table plus random
// ball updates under random stalls, checked against an in-bench predictor.
// Depends on pdgb_pkg and the particle_drag_gravity_bounce_step RTL.
module particle_drag_gravity_bounce_step_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int N_RANDOM       = 1700;
    localparam logic [23:0] NO_CHECK  = 24'h0;
    localparam logic [7:0]  REG_SPARE = 8'd7;

    typedef struct {
        logic signed [23:0] px, py, vx, vy;
        logic [7:0]  r;
        logic [15:0] dt;
    } ball_t;

    typedef struct packed {
        logic signed [23:0] px, py, vx, vy;
    } ball_out_t;

    typedef struct {
        ball_t     stim;
        logic      known;
        ball_out_t res;
    } table_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_addr;
    logic [23:0]  cfg_data;

    logic signed [23:0] grav_q;
    logic [15:0]        drag_k;
    logic [11:0]        fld_w;
    logic [11:0]        fld_h;

    ball_out_t next_state_q[$];
    int  mismatches;
    int  results_seen;
    int  idle_cycles;
    bit  timed_out;
    bit  sink_running;

    particle_drag_gravity_bounce_step dut (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic signed [23:0] clamp24(input logic signed [63:0] v);
        if (v > 64'sd8388607) return 24'sh7FFFFF;
        if (v < -64'sd8388608) return -24'sh800000;
        return v[23:0];
    endfunction

    function automatic logic signed [63:0] scale_tz(input logic signed [63:0] a,
                                                    input logic [63:0] b);
        logic [63:0] m;
        logic [63:0] p;
        m = a[63] ? 64'(-a) : 64'(a);
        p = (m * b) >> 16;
        return a[63] ? -$signed(p) : $signed(p);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic bit at_wall(input logic signed [23:0] p, input logic [11:0] size,
                                   input logic [7:0] r);
        logic signed [63:0] lim;
        lim = ($signed({52'd0, size}) - 2 * $signed({56'd0, r})) * 256;
        return (p <= 0) || (64'(p) >= lim);
    endfunction

    function automatic ball_out_t euler_step(input ball_t b);
        ball_out_t o;
        logic signed [63:0] vx, vy, px, py;
        logic [63:0] spd, f;
        vx = 64'(b.vx);
        vy = 64'(b.vy);
        spd = int_sqrt(64'(vx * vx) + 64'(vy * vy));
        f = (64'(drag_k) * spd * 64'(b.dt)) >> 24;
        vx = 64'(clamp24(vx - scale_tz(vx, f)));
        vy = 64'(clamp24(vy - scale_tz(vy, f)));
        vy = 64'(clamp24(vy + scale_tz(64'(grav_q), 64'(b.dt))));
        px = 64'(clamp24(64'(b.px) + scale_tz(vx, 64'(b.dt))));
        py = 64'(clamp24(64'(b.py) + scale_tz(vy, 64'(b.dt))));
        o.px = px[23:0];
        o.py = py[23:0];
        o.vx = vx[23:0];
        o.vy = vy[23:0];
        if (at_wall(o.px, fld_w, b.r)) o.vx = clamp24(-64'(o.vx));
        if (at_wall(o.py, fld_h, b.r)) o.vy = clamp24(-64'(o.vy));
        return o;
    endfunction

    task automatic write_reg(input logic [7:0] idx, input logic [23:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            pdgb_pkg::REG_GRAVITY: grav_q = val;
            pdgb_pkg::REG_DRAG:    drag_k = val[15:0];
            pdgb_pkg::REG_WIDTH:   fld_w  = val[11:0];
            pdgb_pkg::REG_HEIGHT:  fld_h  = val[11:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Entered at a falling edge right after the last beat.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (next_state_q.size() != 0 && !timed_out) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Drive one beat; optional typed-in result overrides the predictor.
    // Entered at a falling edge; s_tvalid stays high when no gap follows.
    task automatic send_ball(input ball_t b, input bit known, input ball_out_t res);
        int gap;
        ball_out_t exp_o;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        exp_o = known ? res : euler_step(b);
        next_state_q = {next_state_q, exp_o};
        s_tdata  <= {b.dt, b.r, b.vy, b.vx, b.py, b.px};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic ball_t rand_ball(input bit tame);
        ball_t b;
        b.px = 24'($urandom);
        b.py = 24'($urandom);
        b.vx = 24'($urandom);
        b.vy = 24'($urandom);
        b.r  = 8'($urandom);
        b.dt = 16'($urandom);
        if (tame) begin
            b.px = 24'($urandom_range(0, 900 * 256));
            b.py = 24'($urandom_range(0, 700 * 256));
            b.vx = 24'(int'($urandom_range(0, 2000 * 256)) - 1000 * 256);
            b.vy = 24'(int'($urandom_range(0, 2000 * 256)) - 1000 * 256);
            b.r  = 8'($urandom_range(1, 40));
            b.dt = 16'($urandom_range(0, 4000));
        end
        return b;
    endfunction

    function automatic ball_t mk(input int px, input int py, input int vx, input int vy,
                                 input int r, input int dt);
        ball_t b;
        b.px = 24'(px);
        b.py = 24'(py);
        b.vx = 24'(vx);
        b.vy = 24'(vy);
        b.r  = 8'(r);
        b.dt = 16'(dt);
        return b;
    endfunction

    // Output side: random wait before each beat and the scoreboard.
    initial begin
        ball_out_t exp_o;
        ball_out_t got;
        int        wait_left;
        m_tready = 1'b0;
        wait_left = $urandom_range(0, 5);
        wait (sink_running);
        forever begin
            @(negedge aclk);
            if (wait_left != 0) begin
                m_tready <= 1'b0;
                wait_left--;
            end else begin
                m_tready <= 1'b1;
            end
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                results_seen++;
                wait_left = $urandom_range(0, 5);
                got.px = m_tdata[23:0];
                got.py = m_tdata[47:24];
                got.vx = m_tdata[71:48];
                got.vy = m_tdata[95:72];
                if (next_state_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected beat %h", m_tdata);
                end else begin
                    exp_o = next_state_q.pop_front();
                    if (got != exp_o) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch #%0d: exp px %h py %h vx %h vy %h",
                                     results_seen, exp_o.px, exp_o.py, exp_o.vx, exp_o.vy);
                            $display("              got px %h py %h vx %h vy %h",
                                     got.px, got.py, got.vx, got.vy);
                        end
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        table_row_t rows[$];
        table_row_t row;
        ball_out_t none;
        logic [23:0] grav_set[4];
        logic [15:0] drag_set[4];
        logic [11:0] w_set[4];
        logic [11:0] h_set[4];

        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        sink_running = 1'b0;
        grav_q = 24'sd128000;
        drag_k = 16'd655;
        fld_w = 12'd800;
        fld_h = 12'd600;
        none = '{NO_CHECK, NO_CHECK, NO_CHECK, NO_CHECK};
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        sink_running = 1'b1;

        // Directed table at reset defaults; known rows are easy to read off.
        row.known = 1'b1;
        row.stim = mk(100 * 256, 100 * 256, 0, 0, 10, 0);
        row.res = '{24'sd25600, 24'sd25600, 24'sd0, 24'sd0};
        rows = {rows, row};
        // zero position, zero speed, zero dt: bounce on both axes of zero velocity
        row.stim = mk(0, 0, 0, 0, 1, 0);
        row.res = '{24'sd0, 24'sd0, 24'sd0, 24'sd0};
        rows = {rows, row};
        // most negative velocity, no time: negation saturates to +max
        row.stim = mk(0, 0, -8388608, -8388608, 1, 0);
        row.res = '{24'sd0, 24'sd0, 24'sh7FFFFF, 24'sh7FFFFF};
        rows = {rows, row};
        row.known = 1'b0;
        row.res = none;
        row.stim = mk(8388607, 8388607, 8388607, 8388607, 255, 65535);   rows = {rows, row};
        row.stim = mk(-8388608, -8388608, -8388608, 8388607, 0, 65535);  rows = {rows, row};
        row.stim = mk(100 * 256, 100 * 256, 0, 0, 10, 1000);             rows = {rows, row};
        row.stim = mk(100 * 256, 100 * 256, 300 * 256, -200 * 256, 5, 1092);
        rows = {rows, row};
        row.stim = mk(1, 1, -256, -256, 1, 65535);                       rows = {rows, row};
        row.stim = mk(779 * 256, 579 * 256, 5000, 5000, 10, 2000);       rows = {rows, row};
        row.stim = mk(400 * 256, 300 * 256, 8388607, 0, 255, 65535);     rows = {rows, row};
        row.stim = mk(400 * 256, 300 * 256, 0, -8388608, 0, 65535);      rows = {rows, row};
        row.stim = mk(-256, 300 * 256, 100, -100, 20, 1);                rows = {rows, row};
        row.stim = mk(400 * 256, 300 * 256, 60000, 60000, 1, 32768);     rows = {rows, row};

        foreach (rows[i]) send_ball(rows[i].stim, rows[i].known, rows[i].res);
        wait_idle();

        // Settings walk: extremes and typical values, incl. huge drag and tiny field.
        grav_set = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'h00FA00};
        drag_set = '{16'hFFFF, 16'h0000, 16'h0001, 16'h1000};
        w_set    = '{12'd1, 12'd4095, 12'd640, 12'd0};
        h_set    = '{12'd4095, 12'd1, 12'd480, 12'd0};
        write_reg(REG_SPARE, 24'h123456);   // out of range index, ignored
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                write_reg(pdgb_pkg::REG_GRAVITY, grav_set[ph - 1]);
                write_reg(pdgb_pkg::REG_DRAG, {8'd0, drag_set[ph - 1]});
                write_reg(pdgb_pkg::REG_WIDTH, {12'd0, w_set[ph - 1]});
                write_reg(pdgb_pkg::REG_HEIGHT, {12'd0, h_set[ph - 1]});
            end
            for (int n = 0; n < N_RANDOM / 5; n++)
                send_ball(rand_ball($urandom_range(0, 3) != 0), 1'b0, none);
            wait_idle();
        end

        $display("checked %0d results over 5 register settings plus %0d directed rows",
                 results_seen, rows.size());
        if (mismatches == 0 && next_state_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
